// ===== rtl/core/bga_pkg.sv =====
// ----------------------------------------------------------------------------
// bga_pkg
// Shared constants of the block group allocator: field widths, register
// indexes, request kinds, register reset values and default sizing.
// ----------------------------------------------------------------------------
package bga_pkg;

  // default sizing
  localparam int GROUP_COUNT_DEF        = 8;
  localparam int INODES_PER_GROUP_DEF   = 32;
  localparam int INDIRECT_PER_GROUP_DEF = 4;

  // field widths
  localparam int INODE_W     = 16;
  localparam int INDEX_W     = 10;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int COUNT_W     = 16;
  localparam int BLOCK_W     = 32;
  localparam int GROUP_OUT_W = 6;
  localparam int S_DATA_W    = 32;
  localparam int M_DATA_W    = 40;

  // request kinds
  localparam logic ACT_NEAR_HOME = 1'b0;
  localparam logic ACT_SPREAD    = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AREA_START  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_PER  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_OFFSET = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_BLOCKS = 2'd3;

  // register reset values
  localparam logic [CFG_W-1:0] AREA_START_RST  = 16'd2;
  localparam logic [CFG_W-1:0] BLOCKS_PER_RST  = 16'd1024;
  localparam logic [CFG_W-1:0] DATA_OFFSET_RST = 16'd2;
  localparam logic [CFG_W-1:0] DATA_BLOCKS_RST = 16'd1000;

endpackage

// ===== rtl/core/block_group_allocator.sv =====
// ----------------------------------------------------------------------------
// block_group_allocator
// Picks a block group with free data blocks for each request and returns the
// absolute block number; per-group used counts live in a small memory.
// ----------------------------------------------------------------------------
//
//  channel  | dir | tvalid/tready | payload
//  ---------+-----+---------------+------------------------------------------
//  s_*      | in  | yes           | tuser: action; tdata: inode, index
//  m_*      | out | yes           | tuser: all_full; tdata: block, group
//  cfg_*    | in  | write enable  | cfg_index, cfg_data
//
//  a request passes the quotient, modulo, start, scan, block arithmetic and
//  finish steps, skipping the arithmetic when all groups are full; a new
//  request is taken only back in idle. the scan probes up to GROUP_COUNT
//  groups for a near-home request and up to (GROUP_COUNT+1)/2 + GROUP_COUNT
//  for a spread request; one count-memory read per cycle, checked next cycle.
//  used counts come out of reset as zero through per-group valid bits; no
//  clearing pass. a result waiting on m_tready holds the finish step only.
//
module block_group_allocator
  import bga_pkg::*;
#(
  parameter int GROUP_COUNT        = GROUP_COUNT_DEF,
  parameter int INODES_PER_GROUP   = INODES_PER_GROUP_DEF,
  parameter int INDIRECT_PER_GROUP = INDIRECT_PER_GROUP_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // request
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_DATA_W-1:0]  s_tdata,   // [15:0] inode_number, [25:16] indirect_index
  input  logic                 s_tuser,   // [0] action
  // result
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_DATA_W-1:0]  m_tdata,   // [31:0] block_number, [37:32] chosen_group
  output logic                 m_tuser,   // [0] all_full
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int GW = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;

  // reciprocal constants for exact division by constants
  localparam int LH   = $clog2(INODES_PER_GROUP);
  localparam int SH_H = INODE_W + LH;
  localparam logic [INODE_W:0] MAG_H = (INODE_W+1)'(((64'd1 << SH_H)
      + 64'(INODES_PER_GROUP) - 64'd1) / 64'(INODES_PER_GROUP));
  localparam int LI   = $clog2(INDIRECT_PER_GROUP);
  localparam int SH_I = INDEX_W + LI;
  localparam logic [INDEX_W:0] MAG_I = (INDEX_W+1)'(((64'd1 << SH_I)
      + 64'(INDIRECT_PER_GROUP) - 64'd1) / 64'(INDIRECT_PER_GROUP));
  localparam int LN   = $clog2(GROUP_COUNT);
  localparam int SH_N = INODE_W + LN;
  localparam logic [INODE_W:0] MAG_N = (INODE_W+1)'(((64'd1 << SH_N)
      + 64'(GROUP_COUNT) - 64'd1) / 64'(GROUP_COUNT));

  localparam logic [GW-1:0] LAST_G = GW'(GROUP_COUNT - 1);

  // sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_QUOT  = 3'd1;
  localparam logic [2:0] S_MODG  = 3'd2;
  localparam logic [2:0] S_START = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_MUL   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]           state;

  // configuration registers
  logic [CFG_W-1:0]     area_start;
  logic [CFG_W-1:0]     blocks_per;
  logic [CFG_W-1:0]     data_offset;
  logic [CFG_W-1:0]     data_blocks;

  // request and start group
  logic                 act;
  logic [INODE_W-1:0]   x_home;
  logic [INDEX_W-1:0]   idx_q;
  logic [INODE_W-1:0]   v;
  logic [INODE_W-1:0]   qn;
  logic [2*INODE_W:0]   prod_h;
  logic [2*INDEX_W:0]   prod_i;
  logic [2*INODE_W:0]   prod_n;
  logic [INODE_W-1:0]   g0_wide;

  // scan
  logic [GW-1:0]        cur_g;
  logic [GW-1:0]        n;
  logic                 stride2;
  logic                 cur_end;
  logic [GW-1:0]        chk_g;
  logic                 chk_vld;
  logic                 chk_last;
  logic [GW-1:0]        nxt_g;
  logic                 stride2_next;
  logic                 last_probe;
  logic [GW:0]          sum2;

  // count memory
  logic [COUNT_W-1:0]   mem [GROUP_COUNT];
  logic [GROUP_COUNT-1:0] vld;
  logic [COUNT_W-1:0]   rd_data;
  logic                 rd_vld;
  logic [COUNT_W-1:0]   probe_cnt;
  logic                 probe_full;
  logic                 mem_we;

  // result
  logic [GW-1:0]        hit_g;
  logic [COUNT_W-1:0]   hit_cnt;
  logic                 fail;
  logic [BLOCK_W-1:0]   prod;
  logic [BLOCK_W-1:0]   base;

  assign s_tready = (state == S_IDLE);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      area_start  <= AREA_START_RST;
      blocks_per  <= BLOCKS_PER_RST;
      data_offset <= DATA_OFFSET_RST;
      data_blocks <= DATA_BLOCKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AREA_START:  area_start  <= cfg_data;
        REG_BLOCKS_PER:  blocks_per  <= cfg_data;
        REG_DATA_OFFSET: data_offset <= cfg_data;
        REG_DATA_BLOCKS: data_blocks <= cfg_data;
        default: ;
      endcase
    end
  end

  // division datapath
  assign prod_h  = (2*INODE_W+1)'(x_home) * (2*INODE_W+1)'(MAG_H);
  assign prod_i  = (2*INDEX_W+1)'(idx_q) * (2*INDEX_W+1)'(MAG_I);
  assign prod_n  = (2*INODE_W+1)'(v) * (2*INODE_W+1)'(MAG_N);
  assign g0_wide = v - INODE_W'(qn * INODE_W'(GROUP_COUNT));

  // next probe of the scan
  always_comb begin
    sum2         = {1'b0, cur_g} + (GW+1)'(2);
    nxt_g        = cur_g + GW'(1);
    stride2_next = stride2;
    last_probe   = 1'b0;
    if (act == ACT_NEAR_HOME) begin
      last_probe = (n == LAST_G);
      nxt_g      = (cur_g == LAST_G) ? '0 : cur_g + GW'(1);
    end else if (stride2) begin
      if (sum2 >= (GW+1)'(GROUP_COUNT)) begin
        nxt_g        = '0;
        stride2_next = 1'b0;
      end else begin
        nxt_g = sum2[GW-1:0];
      end
    end else begin
      last_probe = (cur_g == LAST_G);
    end
  end

  // probe check on the count read last cycle
  assign probe_cnt  = rd_vld ? rd_data : '0;
  assign probe_full = (probe_cnt >= data_blocks);
  assign mem_we     = (state == S_SCAN) && chk_vld && !probe_full;

  // count memory, one read and one write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[chk_g] <= probe_cnt + COUNT_W'(1);
    end
    rd_data <= mem[cur_g];
    rd_vld  <= vld[cur_g];
  end

  // entry valid bits, a cleared entry reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (mem_we) begin
      vld[chk_g] <= 1'b1;
    end
  end

  // result valid, raised by the finish step and dropped once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_FIN) && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      chk_vld  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            act    <= s_tuser;
            x_home <= s_tdata[INODE_W-1:0] - INODE_W'(1);
            idx_q  <= s_tdata[INODE_W +: INDEX_W];
            state  <= S_QUOT;
          end
        end
        S_QUOT: begin
          if (act == ACT_SPREAD) begin
            v <= INODE_W'(prod_i >> SH_I) + INODE_W'(1);
          end else begin
            v <= INODE_W'(prod_h >> SH_H);
          end
          state <= S_MODG;
        end
        S_MODG: begin
          qn    <= INODE_W'(prod_n >> SH_N);
          state <= S_START;
        end
        S_START: begin
          cur_g   <= g0_wide[GW-1:0];
          n       <= '0;
          stride2 <= 1'b1;
          cur_end <= 1'b0;
          chk_vld <= 1'b0;
          state   <= S_SCAN;
        end
        S_SCAN: begin
          if (chk_vld && !probe_full) begin
            hit_g   <= chk_g;
            hit_cnt <= probe_cnt;
            fail    <= 1'b0;
            chk_vld <= 1'b0;
            state   <= S_MUL;
          end else if (chk_vld && chk_last) begin
            fail    <= 1'b1;
            chk_vld <= 1'b0;
            state   <= S_FIN;
          end else begin
            chk_vld  <= !cur_end;
            chk_g    <= cur_g;
            chk_last <= last_probe;
            if (!cur_end) begin
              cur_g   <= nxt_g;
              n       <= n + GW'(1);
              stride2 <= stride2_next;
              cur_end <= last_probe;
            end
          end
        end
        S_MUL: begin
          prod  <= BLOCK_W'(hit_g) * BLOCK_W'(blocks_per);
          base  <= BLOCK_W'(area_start) + BLOCK_W'(data_offset) + BLOCK_W'(hit_cnt);
          state <= S_FIN;
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tuser  <= fail;
            if (fail) begin
              m_tdata <= '0;
            end else begin
              m_tdata <= {(M_DATA_W-BLOCK_W-GROUP_OUT_W)'(0),
                          GROUP_OUT_W'(hit_g), prod + base};
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a count update is followed by the block number arithmetic
  a_write_then_mul: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> (state == S_MUL))
    else $error("count update not followed by block arithmetic");

  // results come only from the finish step
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == S_FIN))
    else $error("result raised outside finish step");

  // a full answer carries no block and no group
  a_full_is_empty: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("full answer carries data");

  // probed groups stay within the group range
  a_probe_range: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SCAN) && chk_vld) |-> (chk_g <= LAST_G))
    else $error("probe outside group range");

endmodule

// ===== test/tb_block_group_allocator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_block_group_allocator
// Self-checking bench for the block group allocator. A directed table covers
// register extremes, both request kinds, wrapped inode numbers, counts above
// a lowered capacity and the all-groups-full answer. Random phases follow,
// each with fresh register values and capacities mostly near the current
// used counts. Both stream sides idle at random, and the result side holds
// off once for a long stretch. Every result transaction is checked against a
// local allocation model.
// ----------------------------------------------------------------------------
module tb_block_group_allocator;
  import bga_pkg::*;

  localparam int GROUPS       = GROUP_COUNT_DEF;
  localparam int INODES_PER   = INODES_PER_GROUP_DEF;
  localparam int INDIRECT_PER = INDIRECT_PER_GROUP_DEF;
  localparam int RANDOM_ITEMS = 730;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 24;
  localparam int CYCLE_LIMIT  = 600_000;

  typedef struct packed {
    logic [BLOCK_W-1:0]     block;
    logic [GROUP_OUT_W-1:0] group;
    logic                   full;
  } alloc_result_t;

  typedef struct packed {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] reg_sel;
    logic [CFG_W-1:0]     reg_val;
    logic                 act;
    logic [INODE_W-1:0]   inode;
    logic [INDEX_W-1:0]   idx;
    bit                   typed;
    logic [BLOCK_W-1:0]   exp_block;
    logic [GROUP_OUT_W-1:0] exp_group;
    logic                 exp_full;
  } stim_row_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_DATA_W-1:0]  s_tdata;   // [15:0] inode_number, [25:16] indirect_index
  logic                 s_tuser;   // [0] action
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_DATA_W-1:0]  m_tdata;   // [31:0] block_number, [37:32] chosen_group
  logic                 m_tuser;   // [0] all_full
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  // model state: register copies and per-group used counts
  logic [CFG_W-1:0]   area_start  = AREA_START_RST;
  logic [CFG_W-1:0]   blocks_per  = BLOCKS_PER_RST;
  logic [CFG_W-1:0]   data_offset = DATA_OFFSET_RST;
  logic [CFG_W-1:0]   data_blocks = DATA_BLOCKS_RST;
  logic [COUNT_W-1:0] used_count [GROUPS];

  alloc_result_t pending_allocs [$];
  alloc_result_t expected_alloc;
  stim_row_t     directed_rows [$];
  int            errors = 0;
  int            cycle_count = 0;
  bit            steady = 0;
  bit            hold_off_req = 0;

  block_group_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_block_group_allocator failed");
      $finish;
    end
  end

  task automatic report_mismatch(string what, logic [BLOCK_W-1:0] got,
                                 logic [BLOCK_W-1:0] want);
    errors++;
    if (errors <= 40)
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // allocation model: picks the group, forms the block number, bumps the count
  function automatic alloc_result_t predict_alloc(logic act, logic [INODE_W-1:0] inode,
                                                  logic [INDEX_W-1:0] idx);
    logic [INODE_W-1:0] inode_m1;
    int            g;
    int            stride;
    bit            found;
    bit            exhausted;
    alloc_result_t res;
    found     = 1'b0;
    exhausted = 1'b0;
    res       = '0;
    if (act == ACT_NEAR_HOME) begin
      // one-based inode, so zero wraps to the top of the 16-bit range
      inode_m1 = inode - 1'b1;
      g = (int'(inode_m1) / INODES_PER) % GROUPS;
      for (int n = 0; n < GROUPS && !found; n++) begin
        if (used_count[g] < data_blocks) found = 1'b1;
        else g = (g + 1) % GROUPS;
      end
    end else begin
      // spread: stride 2 from the indexed group, then a stride 1 sweep from 0
      g = (int'(idx) / INDIRECT_PER + 1) % GROUPS;
      stride = 2;
      while (!found && !exhausted) begin
        if (used_count[g] < data_blocks) begin
          found = 1'b1;
        end else begin
          g += stride;
          if (g >= GROUPS) begin
            if (stride == 1) exhausted = 1'b1;
            else begin
              g = 0;
              stride = 1;
            end
          end
        end
      end
    end
    if (found) begin
      res.block = 32'(area_start) + 32'(g) * 32'(blocks_per) + 32'(data_offset)
                + 32'(used_count[g]);
      res.group = GROUP_OUT_W'(g);
      used_count[g] = used_count[g] + 1'b1;
    end else begin
      res.full = 1'b1;
    end
    return res;
  endfunction

  // wait until every result is back and the block has settled
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_allocs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] sel, logic [CFG_W-1:0] val);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (sel)
      REG_AREA_START:  area_start  = val;
      REG_BLOCKS_PER:  blocks_per  = val;
      REG_DATA_OFFSET: data_offset = val;
      REG_DATA_BLOCKS: data_blocks = val;
      default: ;
    endcase
  endtask

  // offer one request, record its expected result, then maybe idle
  task automatic send_request(logic act, logic [INODE_W-1:0] inode, logic [INDEX_W-1:0] idx,
                              bit typed, alloc_result_t typed_exp);
    alloc_result_t predicted;
    int            gap;
    int            r;
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= S_DATA_W'({idx, inode});
    do @(posedge clk); while (!s_tready);
    predicted = predict_alloc(act, inode, idx);
    pending_allocs.push_back(typed ? typed_exp : predicted);
    r = $urandom_range(0, 99);
    if (steady || r < 60) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 60);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // register value biased toward its extremes
  function automatic logic [CFG_W-1:0] pick_field(int floor_val);
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) return CFG_W'(floor_val);
    if (r == 1) return '1;
    return CFG_W'($urandom_range(floor_val, 65535));
  endfunction

  // result side: random ready stretches and stalls, one long hold-off
  initial begin : receiver
    int stall_len;
    int r;
    m_tready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (steady) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) stall_len = 0;
        else if (r < 90) stall_len = $urandom_range(1, 4);
        else stall_len = $urandom_range(10, 60);
        if (stall_len > 0) begin
          m_tready <= 1'b0;
          repeat (stall_len) @(posedge clk);
        end
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_allocs.size() == 0) begin
        report_mismatch("unexpected result", m_tdata[BLOCK_W-1:0], '0);
      end else begin
        expected_alloc = pending_allocs.pop_front();
        if (m_tdata[BLOCK_W-1:0] !== expected_alloc.block)
          report_mismatch("block_number", m_tdata[BLOCK_W-1:0], expected_alloc.block);
        if (m_tdata[BLOCK_W +: GROUP_OUT_W] !== expected_alloc.group)
          report_mismatch("chosen_group", BLOCK_W'(m_tdata[BLOCK_W +: GROUP_OUT_W]),
                          BLOCK_W'(expected_alloc.group));
        if (m_tuser !== expected_alloc.full)
          report_mismatch("all_full", BLOCK_W'(m_tuser), BLOCK_W'(expected_alloc.full));
      end
    end
  end

  // stimulus
  initial begin : stimulus
    stim_row_t        row;
    int               sent;
    int               burst;
    int               phase;
    logic [CFG_W-1:0] cap;
    logic [CFG_W-1:0] hi_cnt;
    logic [CFG_W-1:0] lo_cnt;
    logic             act;
    logic [INODE_W-1:0] inode;
    int               r;

    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    foreach (used_count[g]) used_count[g] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table: registers start at their reset values, counts at zero
    directed_rows = '{
      '{1'b0, REG_AREA_START, 16'd0, ACT_NEAR_HOME, 16'd1,     10'd0,    1'b1, 32'd4,    6'd0, 1'b0},
      '{1'b0, REG_AREA_START, 16'd0, ACT_NEAR_HOME, 16'd65535, 10'd1023, 1'b1, 32'd7172, 6'd7, 1'b0},
      // inode zero wraps into the last group
      '{1'b0, REG_AREA_START, 16'd0, ACT_NEAR_HOME, 16'd0,     10'd0,    1'b1, 32'd7173, 6'd7, 1'b0},
      '{1'b0, REG_AREA_START, 16'd0, ACT_SPREAD,    16'd0,     10'd0,    1'b1, 32'd1028, 6'd1, 1'b0},
      '{1'b0, REG_AREA_START, 16'd0, ACT_SPREAD,    16'd65535, 10'd1023, 1'b1, 32'd5,    6'd0, 1'b0},
      '{1'b0, REG_AREA_START, 16'd0, ACT_NEAR_HOME, 16'd33,    10'd0,    1'b1, 32'd1029, 6'd1, 1'b0},
      // home group past the last one folds back
      '{1'b0, REG_AREA_START, 16'd0, ACT_NEAR_HOME, 16'd257,   10'd0,    1'b1, 32'd6,    6'd0, 1'b0},
      '{1'b0, REG_AREA_START, 16'd0, ACT_SPREAD,    16'd1,     10'd30,   1'b0, 32'd0,    6'd0, 1'b0},
      // capacity one: groups already used beyond it count as full
      '{1'b1, REG_DATA_BLOCKS, 16'd1, ACT_NEAR_HOME, 16'd0,    10'd0,    1'b0, 32'd0,    6'd0, 1'b0},
      '{1'b0, REG_AREA_START, 16'd0, ACT_SPREAD,    16'd1,     10'd0,    1'b0, 32'd0,    6'd0, 1'b0},
      '{1'b0, REG_AREA_START, 16'd0, ACT_SPREAD,    16'd1,     10'd4,    1'b0, 32'd0,    6'd0, 1'b0},
      '{1'b0, REG_AREA_START, 16'd0, ACT_SPREAD,    16'd1,     10'd20,   1'b0, 32'd0,    6'd0, 1'b0},
      // stride 2 runs off the end, sweep from group 0
      '{1'b0, REG_AREA_START, 16'd0, ACT_SPREAD,    16'd1,     10'd24,   1'b0, 32'd0,    6'd0, 1'b0},
      '{1'b0, REG_AREA_START, 16'd0, ACT_NEAR_HOME, 16'd1,     10'd0,    1'b0, 32'd0,    6'd0, 1'b0},
      // every group full
      '{1'b0, REG_AREA_START, 16'd0, ACT_NEAR_HOME, 16'd1,     10'd0,    1'b1, 32'd0,    6'd0, 1'b1},
      '{1'b0, REG_AREA_START, 16'd0, ACT_SPREAD,    16'd1,     10'd1023, 1'b1, 32'd0,    6'd0, 1'b1},
      // register maxima
      '{1'b1, REG_DATA_BLOCKS, 16'd65535, ACT_NEAR_HOME, 16'd0, 10'd0,   1'b0, 32'd0,    6'd0, 1'b0},
      '{1'b1, REG_AREA_START,  16'd65535, ACT_NEAR_HOME, 16'd0, 10'd0,   1'b0, 32'd0,    6'd0, 1'b0},
      '{1'b1, REG_BLOCKS_PER,  16'd65535, ACT_NEAR_HOME, 16'd0, 10'd0,   1'b0, 32'd0,    6'd0, 1'b0},
      '{1'b1, REG_DATA_OFFSET, 16'd65535, ACT_NEAR_HOME, 16'd0, 10'd0,   1'b0, 32'd0,    6'd0, 1'b0},
      '{1'b0, REG_AREA_START, 16'd0, ACT_NEAR_HOME, 16'd65535, 10'd0,    1'b0, 32'd0,    6'd0, 1'b0},
      '{1'b0, REG_AREA_START, 16'd0, ACT_SPREAD,    16'd1,     10'd1023, 1'b0, 32'd0,    6'd0, 1'b0},
      // register minima
      '{1'b1, REG_AREA_START,  16'd0, ACT_NEAR_HOME, 16'd0,    10'd0,    1'b0, 32'd0,    6'd0, 1'b0},
      '{1'b1, REG_BLOCKS_PER,  16'd1, ACT_NEAR_HOME, 16'd0,    10'd0,    1'b0, 32'd0,    6'd0, 1'b0},
      '{1'b1, REG_DATA_OFFSET, 16'd0, ACT_NEAR_HOME, 16'd0,    10'd0,    1'b0, 32'd0,    6'd0, 1'b0},
      '{1'b0, REG_AREA_START, 16'd0, ACT_NEAR_HOME, 16'd1,     10'd0,    1'b0, 32'd0,    6'd0, 1'b0},
      '{1'b0, REG_AREA_START, 16'd0, ACT_SPREAD,    16'd1,     10'd12,   1'b0, 32'd0,    6'd0, 1'b0}
    };
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_cfg) write_reg(row.reg_sel, row.reg_val);
      else send_request(row.act, row.inode, row.idx, row.typed,
                        '{row.exp_block, row.exp_group, row.exp_full});
    end

    // random phases, capacity mostly placed near the current counts
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      hi_cnt = '0;
      lo_cnt = '1;
      foreach (used_count[g]) begin
        if (used_count[g] > hi_cnt) hi_cnt = used_count[g];
        if (used_count[g] < lo_cnt) lo_cnt = used_count[g];
      end
      case ($urandom_range(0, 5))
        0:       cap = '1;
        1:       cap = 16'd1;
        2:       cap = lo_cnt + CFG_W'($urandom_range(0, 3));
        3:       cap = CFG_W'($urandom_range(1, int'(hi_cnt) + 1));
        default: cap = hi_cnt + CFG_W'($urandom_range(1, 12));
      endcase
      if (cap == '0) cap = 16'd1;
      write_reg(REG_AREA_START, pick_field(0));
      write_reg(REG_BLOCKS_PER, pick_field(1));
      write_reg(REG_DATA_OFFSET, pick_field(0));
      write_reg(REG_DATA_BLOCKS, cap);

      steady = ($urandom_range(0, 5) == 0);
      // one long hold-off on the result side while requests keep coming
      if (phase == 2) begin
        steady = 1'b0;
        hold_off_req = 1'b1;
      end
      burst = $urandom_range(10, 50);
      for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        act = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 19);
        if (r == 0) inode = '0;
        else if (r == 1) inode = '1;
        else inode = INODE_W'($urandom);
        send_request(act, inode, INDEX_W'($urandom_range(0, 1023)), 1'b0, '0);
        sent++;
      end
      steady = 1'b0;
      phase++;
    end

    wait_idle();
    if (errors == 0) $display("tb_block_group_allocator passed");
    else $display("tb_block_group_allocator failed");
    $finish;
  end

endmodule
